// ===== rtl/baro_pressure_compensation_top_macros.svh =====
// assertion macros for the pressure compensation top level
`ifndef BARO_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BARO_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// shared types, widths and constant tables of the pressure compensation block
package bpc_pkg;

  localparam int unsigned NSTG        = 9;
  localparam int unsigned QF          = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned PFB_DEFAULT = 6;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 88;
  localparam int unsigned RECIP_W     = 31;
  localparam int unsigned OSR_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LOW  = 2'd0,
    REG_COEF_MID  = 2'd1,
    REG_COEF_HIGH = 2'd2,
    REG_OSR       = 2'd3
  } cfg_reg_e;

  // round(2^48 / scale) for each oversampling setting
  localparam logic [RECIP_W-1:0] RECIP_TAB [8] = '{
    RECIP_W'(((64'd1 << 48) + 64'd262144) / 64'd524288),
    RECIP_W'(((64'd1 << 48) + 64'd786432) / 64'd1572864),
    RECIP_W'(((64'd1 << 48) + 64'd1835008) / 64'd3670016),
    RECIP_W'(((64'd1 << 48) + 64'd3932160) / 64'd7864320),
    RECIP_W'(((64'd1 << 48) + 64'd126976) / 64'd253952),
    RECIP_W'(((64'd1 << 48) + 64'd258048) / 64'd516096),
    RECIP_W'(((64'd1 << 48) + 64'd520192) / 64'd1040384),
    RECIP_W'(((64'd1 << 48) + 64'd1044480) / 64'd2088960)
  };

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
    logic [OSR_W-1:0]   osr;
  } coef_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctrl_t;

endpackage

// ===== rtl/bpc_cfg.sv =====
// calibration and oversampling registers with coefficient unpacking
module bpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output bpc_pkg::coef_t                 coef_o
);
  import bpc_pkg::*;

  logic [63:0]      low_q;
  logic [63:0]      mid_q;
  logic [15:0]      high_q;
  logic [OSR_W-1:0] osr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      mid_q  <= '0;
      high_q <= '0;
      osr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_LOW: begin
          low_q <= cfg_wdata_i;
        end
        REG_COEF_MID: begin
          mid_q <= cfg_wdata_i;
        end
        REG_COEF_HIGH: begin
          high_q <= cfg_wdata_i[15:0];
        end
        REG_OSR: begin
          osr_q <= cfg_wdata_i[OSR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coef_o.c0  = $signed(low_q[63:52]);
    coef_o.c1  = $signed(low_q[51:40]);
    coef_o.c00 = $signed(low_q[39:20]);
    coef_o.c10 = $signed(low_q[19:0]);
    coef_o.c01 = $signed(mid_q[63:48]);
    coef_o.c11 = $signed(mid_q[47:32]);
    coef_o.c20 = $signed(mid_q[31:16]);
    coef_o.c21 = $signed(mid_q[15:0]);
    coef_o.c30 = $signed(high_q);
    coef_o.osr = osr_q;
  end

endmodule

// ===== rtl/bpc_ctrl.sv =====
// valid bits and per-stage load enables of the compensation pipeline
module bpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                m_ready_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  output bpc_pkg::pipe_ctrl_t pipe_o
);
  import bpc_pkg::*;

  logic [NSTG:0]   en;
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;

  // a stage loads when it is empty or the one after it moves
  assign en[NSTG] = m_ready_i;
  for (genvar g = 0; g < NSTG; g++) begin : g_en
    assign en[g] = !vld_q[g] || en[g+1];
  end

  assign vld_d = (en[NSTG-1:0] & {vld_q[NSTG-2:0], s_valid_i}) | (~en[NSTG-1:0] & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_ready_o  = en[0];
  assign m_valid_o  = vld_q[NSTG-1];
  assign pipe_o.en  = en[NSTG-1:0];
  assign pipe_o.vld = vld_q;

endmodule

// ===== rtl/bpc_datapath.sv =====
// nine-stage datapath: scaling, polynomial evaluation, rounding and saturation
module bpc_datapath #(
  parameter int unsigned PRESSURE_FRAC_BITS = bpc_pkg::PFB_DEFAULT
) (
  input  logic                           clk_i,
  input  bpc_pkg::pipe_ctrl_t            pipe_i,
  input  bpc_pkg::coef_t                 coef_i,
  input  logic [bpc_pkg::IN_DATA_W-1:0]  s_data_i,
  output logic [bpc_pkg::OUT_DATA_W-1:0] m_data_o
);
  import bpc_pkg::*;

  localparam int unsigned PW    = 60;
  localparam int unsigned SHIFT = QF - PRESSURE_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (SHIFT - 1));
  localparam logic signed [PW-1:0] POUT_MAX = $signed({{(PW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [PW-1:0] POUT_MIN = $signed({{(PW-31){1'b1}}, {31{1'b0}}});
  localparam logic signed [25:0]   TOUT_MAX = $signed({3'b000, {23{1'b1}}});
  localparam logic signed [25:0]   TOUT_MIN = $signed({3'b111, {23{1'b0}}});

  // round to nearest, half up, dropping 24 fraction bits
  function automatic logic signed [35:0] rnd24(input logic signed [59:0] x);
    logic signed [59:0] s;
    s = x + 60'sd8388608;
    return $signed(s[59:24]);
  endfunction

  // stage 1
  logic signed [23:0] praw, traw;
  logic signed [55:0] pm_d, pm_q;
  logic signed [28:0] ts1_d, ts1_q;
  logic signed [35:0] tm_d, tm_q;
  logic [31:0]        time1_q;

  assign praw  = $signed(s_data_i[23:0]);
  assign traw  = $signed(s_data_i[47:24]);
  assign pm_d  = praw * $signed({1'b0, RECIP_TAB[coef_i.osr]});
  assign ts1_d = $signed({traw, 5'b00000});
  assign tm_d  = coef_i.c1 * traw;

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[0]) begin
      pm_q    <= pm_d;
      ts1_q   <= ts1_d;
      tm_q    <= tm_d;
      time1_q <= s_data_i[79:48];
    end
  end

  // stage 2
  logic signed [55:0] psum;
  logic signed [30:0] ps2_d, ps2_q;
  logic signed [36:0] tnum, tsum;
  logic signed [25:0] tsh;
  logic signed [23:0] tsat_d, t2_q;
  logic signed [28:0] ts2_q;
  logic [31:0]        time2_q;

  assign psum  = pm_q + 56'sd8388608;
  assign ps2_d = $signed(psum[54:24]);
  assign tnum  = (37'(coef_i.c0) <<< 18) + 37'(tm_q);
  assign tsum  = tnum + 37'sd1024;
  assign tsh   = $signed(tsum[36:11]);

  always_comb begin
    if (tsh > TOUT_MAX) begin
      tsat_d = TOUT_MAX[23:0];
    end else if (tsh < TOUT_MIN) begin
      tsat_d = TOUT_MIN[23:0];
    end else begin
      tsat_d = tsh[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[1]) begin
      ps2_q   <= ps2_d;
      ts2_q   <= ts1_q;
      t2_q    <= tsat_d;
      time2_q <= time1_q;
    end
  end

  // stage 3
  logic signed [47:0] a_d, a_q, d_d, d_q;
  logic signed [44:0] tc_d, tc3_q;
  logic signed [30:0] ps3_q;
  logic signed [28:0] ts3_q;
  logic signed [23:0] t3_q;
  logic [31:0]        time3_q;

  assign a_d  = (48'(coef_i.c20) <<< 24) + ps2_q * coef_i.c30;
  assign d_d  = (48'(coef_i.c11) <<< 24) + ps2_q * coef_i.c21;
  assign tc_d = ts2_q * coef_i.c01;

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[2]) begin
      a_q     <= a_d;
      d_q     <= d_d;
      tc3_q   <= tc_d;
      ps3_q   <= ps2_q;
      ts3_q   <= ts2_q;
      t3_q    <= t2_q;
      time3_q <= time2_q;
    end
  end

  // stage 4
  logic signed [54:0] pah_d, pah_q, pdh_d, pdh_q;
  logic signed [55:0] pal_d, pal_q, pdl_d, pdl_q;
  logic signed [30:0] ps4_q;
  logic signed [28:0] ts4_q;
  logic signed [44:0] tc4_q;
  logic signed [23:0] t4_q;
  logic [31:0]        time4_q;

  assign pah_d = ps3_q * $signed(a_q[47:24]);
  assign pal_d = ps3_q * $signed({1'b0, a_q[23:0]});
  assign pdh_d = ps3_q * $signed(d_q[47:24]);
  assign pdl_d = ps3_q * $signed({1'b0, d_q[23:0]});

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[3]) begin
      pah_q   <= pah_d;
      pal_q   <= pal_d;
      pdh_q   <= pdh_d;
      pdl_q   <= pdl_d;
      ps4_q   <= ps3_q;
      ts4_q   <= ts3_q;
      tc4_q   <= tc3_q;
      t4_q    <= t3_q;
      time4_q <= time3_q;
    end
  end

  // stage 5
  logic signed [51:0] b_d, b_q, e_d, e_q;
  logic signed [30:0] ps5_q;
  logic signed [28:0] ts5_q;
  logic signed [44:0] tc5_q;
  logic signed [23:0] t5_q;
  logic [31:0]        time5_q;

  assign b_d = (52'(coef_i.c10) <<< 24) + 52'(pah_q) + 52'(rnd24(60'(pal_q)));
  assign e_d = 52'(pdh_q) + 52'(rnd24(60'(pdl_q)));

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[4]) begin
      b_q     <= b_d;
      e_q     <= e_d;
      ps5_q   <= ps4_q;
      ts5_q   <= ts4_q;
      tc5_q   <= tc4_q;
      t5_q    <= t4_q;
      time5_q <= time4_q;
    end
  end

  // stage 6
  logic signed [58:0] pbh_d, pbh_q;
  logic signed [55:0] pbl_d, pbl_q;
  logic signed [56:0] teh_d, teh_q;
  logic signed [53:0] tel_d, tel_q;
  logic signed [44:0] tc6_q;
  logic signed [23:0] t6_q;
  logic [31:0]        time6_q;

  assign pbh_d = ps5_q * $signed(b_q[51:24]);
  assign pbl_d = ps5_q * $signed({1'b0, b_q[23:0]});
  assign teh_d = ts5_q * $signed(e_q[51:24]);
  assign tel_d = ts5_q * $signed({1'b0, e_q[23:0]});

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[5]) begin
      pbh_q   <= pbh_d;
      pbl_q   <= pbl_d;
      teh_q   <= teh_d;
      tel_q   <= tel_d;
      tc6_q   <= tc5_q;
      t6_q    <= t5_q;
      time6_q <= time5_q;
    end
  end

  // stage 7
  logic signed [PW-1:0] p_d, p_q, cr_d, cr_q;
  logic signed [44:0]   tc7_q;
  logic signed [23:0]   t7_q;
  logic [31:0]          time7_q;

  assign p_d  = (PW'(coef_i.c00) <<< 24) + PW'(pbh_q) + PW'(rnd24(PW'(pbl_q)));
  assign cr_d = PW'(teh_q) + PW'(rnd24(PW'(tel_q)));

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[6]) begin
      p_q     <= p_d;
      cr_q    <= cr_d;
      tc7_q   <= tc6_q;
      t7_q    <= t6_q;
      time7_q <= time6_q;
    end
  end

  // stage 8
  logic signed [PW-1:0] tot;
  logic signed [PW-1:0] pr_d, pr_q;
  logic signed [23:0]   t8_q;
  logic [31:0]          time8_q;

  assign tot  = p_q + cr_q + PW'(tc7_q) + HALF;
  assign pr_d = tot >>> SHIFT;

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[7]) begin
      pr_q    <= pr_d;
      t8_q    <= t7_q;
      time8_q <= time7_q;
    end
  end

  // stage 9, output register
  logic signed [31:0] psat_d, psat_q;
  logic signed [23:0] t9_q;
  logic [31:0]        time9_q;

  always_comb begin
    if (pr_q > POUT_MAX) begin
      psat_d = POUT_MAX[31:0];
    end else if (pr_q < POUT_MIN) begin
      psat_d = POUT_MIN[31:0];
    end else begin
      psat_d = pr_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[8]) begin
      psat_q  <= psat_d;
      t9_q    <= t8_q;
      time9_q <= time8_q;
    end
  end

  assign m_data_o = {time9_q, t9_q, psat_q};

endmodule

// ===== rtl/baro_pressure_compensation_top.sv =====
// top level of the barometric pressure and temperature compensation pipeline
// an accepted beat is loaded into stage 1 and moves on through stages 2 to 9; m_axis presents stage 9
// throughput: one beat per cycle through nine register stages while m_axis_tready is high
// a stalled output holds its stage; empty stages further up still accept beats
// reset clears all valid bits and the calibration and oversampling registers
`include "baro_pressure_compensation_top_macros.svh"

module baro_pressure_compensation_top #(
  parameter int unsigned PRESSURE_FRAC_BITS = bpc_pkg::PFB_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pressure_raw [23:0], temperature_raw [47:24], sample_time [79:48]
  input  logic [bpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pressure_fixed [31:0], temperature_fixed [55:32], time_out [87:56]
  output logic [bpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bpc_pkg::*;

  coef_t      coef;
  pipe_ctrl_t pipe;

  bpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  bpc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .pipe_o    (pipe)
  );

  bpc_datapath #(
    .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .pipe_i   (pipe),
    .coef_i   (coef),
    .s_data_i (s_axis_tdata),
    .m_data_o (m_axis_tdata)
  );

  `BPC_ASSERT_SAME(a_empty_out_takes, !m_axis_tvalid, s_axis_tready, "empty output stage but input stalled")
  `BPC_ASSERT_SAME(a_ready_flows, m_axis_tready, s_axis_tready, "sink ready but input stalled")
  `BPC_ASSERT_NEXT(a_beat_enters, s_axis_tvalid && s_axis_tready, pipe.vld[0], "accepted beat missing in first stage")

endmodule
